@@ hdl/rrj_pkg.sv @@
// ---------------------------------------------------------------------------
// rrj_pkg
// Shared types, constants and fixed-point helpers for the reprojection
// residual and jacobian pipeline.
// ---------------------------------------------------------------------------
package rrj_pkg;

  // data formats
  localparam int FRAC_BITS_DEF = 16;
  localparam int QUAT_BITS     = 30;
  localparam int DATA_W        = 32;
  localparam int FOCAL_W       = 31;
  localparam int PROD_W        = 64;
  localparam int WIDE_W        = 66;

  // divider geometry: quotient clamped to QUO_W bits, remainder below the divisor
  localparam int NUM_W     = 64;
  localparam int QUO_W     = 34;
  localparam int REM_W     = 32;
  localparam int NUM_LANES = 6;

  // results per transaction and intake gap
  localparam int RESULTS_PER_ITEM = 3;
  localparam int GAP_W            = 2;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_X  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_Y  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd3;

  // configuration reset values
  localparam logic [FOCAL_W-1:0]       FOCAL_X_RST  = 31'd32768000;
  localparam logic [FOCAL_W-1:0]       FOCAL_Y_RST  = 31'd32768000;
  localparam logic signed [DATA_W-1:0] CENTER_X_RST = 32'sd20971520;
  localparam logic signed [DATA_W-1:0] CENTER_Y_RST = 32'sd15728640;

  // result kinds
  typedef enum logic [1:0] {
    ROW_RESID = 2'd0,
    ROW_JAC0  = 2'd1,
    ROW_JAC1  = 2'd2
  } row_kind_t;

  typedef logic signed [WIDE_W-1:0] wide_t;

  localparam logic signed [DATA_W-1:0] QUAT_LIM = 32'sd1073741824;
  localparam wide_t ONE60   = wide_t'(1) <<< (2 * QUAT_BITS);
  localparam wide_t S32_MAX = wide_t'(64'sd2147483647);
  localparam wide_t S32_MIN = wide_t'(-64'sd2147483648);

  // one divider lane
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] low;
    logic [QUO_W-1:0] quo;
    logic             neg;
    logic             ovf;
  } dlane_t;

  // data that rides along the divider
  typedef struct packed {
    logic                   ok;
    logic [REM_W-1:0]       den;
    logic [8:0][DATA_W-1:0] rm;
    logic [DATA_W-1:0]      obs_u;
    logic [DATA_W-1:0]      obs_v;
  } dside_t;

  function automatic wide_t wx(input logic signed [PROD_W-1:0] v);
    return wide_t'(v);
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(input wide_t v);
    if (v > S32_MAX) return DATA_W'(S32_MAX);
    if (v < S32_MIN) return DATA_W'(S32_MIN);
    return DATA_W'(v);
  endfunction

  // round to nearest, ties toward plus infinity
  function automatic wide_t rnd_shift(input wide_t v, input int unsigned s);
    wide_t half;
    half = wide_t'(1) <<< (s - 1);
    return (v + half) >>> s;
  endfunction

  function automatic logic signed [DATA_W-1:0] clamp_quat(input logic signed [DATA_W-1:0] q);
    if (q > QUAT_LIM) return QUAT_LIM;
    if (q < -QUAT_LIM) return -QUAT_LIM;
    return q;
  endfunction

  function automatic logic signed [DATA_W-1:0] rot_entry(input wide_t v);
    return sat32(rnd_shift(v, QUAT_BITS));
  endfunction

  // magnitude plus half divisor, overflow check against the quotient range
  function automatic dlane_t div_init(input logic signed [NUM_W-1:0] n,
                                      input logic [REM_W-1:0] d);
    logic [NUM_W-1:0] mag;
    logic [NUM_W-1:0] num;
    dlane_t           o;
    mag   = n[NUM_W-1] ? NUM_W'(-n) : NUM_W'(n);
    num   = mag + NUM_W'(d >> 1);
    o.neg = n[NUM_W-1];
    o.rem = REM_W'(num[NUM_W-1:QUO_W]);
    o.ovf = REM_W'(num[NUM_W-1:QUO_W]) >= d;
    o.low = num[QUO_W-1:0];
    o.quo = '0;
    return o;
  endfunction

  // one restoring step: one quotient bit
  function automatic dlane_t div_step(input dlane_t l, input logic [REM_W-1:0] d);
    logic [REM_W:0] t;
    dlane_t         o;
    t     = {l.rem, l.low[QUO_W-1]};
    o     = l;
    o.low = {l.low[QUO_W-2:0], 1'b0};
    if (t >= {1'b0, d}) begin
      o.rem = REM_W'(t - {1'b0, d});
      o.quo = {l.quo[QUO_W-2:0], 1'b1};
    end else begin
      o.rem = t[REM_W-1:0];
      o.quo = {l.quo[QUO_W-2:0], 1'b0};
    end
    return o;
  endfunction

  // signed quotient, clamped to the quotient range on overflow
  function automatic wide_t quo_value(input dlane_t l);
    logic [QUO_W-1:0] m;
    wide_t            w;
    m = l.ovf ? {QUO_W{1'b1}} : l.quo;
    w = wide_t'(m);
    return l.neg ? -w : w;
  endfunction

endpackage

@@ hdl/reprojection_residual_jacobian_top.sv @@
// ---------------------------------------------------------------------------
// reprojection_residual_jacobian_top
// Pinhole reprojection residual and point/pose jacobian, fully pipelined.
// ---------------------------------------------------------------------------
// Usage:
//   A transaction is taken at a clock edge where start is high and busy is
//   low. busy then stays high while the intake gap counter runs down, so
//   intake is spaced to fit each result burst; the pipeline behind it
//   holds several transactions at once.
//   Each transaction yields three results on consecutive cycles, each shown
//   for one cycle with out_valid high: the residual, then jacobian row 0,
//   then row 1 with out_last set. The receiver cannot stall.
//   Pipeline: seven front stages (rotation, camera point, numerators), 34
//   divider stages (one quotient bit each, six lanes sharing the depth as
//   divisor), five back stages for the jacobian products and one output
//   register. The intake spacing is set by the three results per
//   transaction on the result port.
//   Configuration writes are taken at any edge with cfg_we high and must
//   only happen while no transaction is in flight.
//   Synchronous reset clears all valid bits and the intake gap counter and
//   restores the intrinsics; busy is high while rst_n is low.
// ---------------------------------------------------------------------------
module reprojection_residual_jacobian_top
  import rrj_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [DATA_W-1:0]    in_point_x,
  input  logic signed [DATA_W-1:0]    in_point_y,
  input  logic signed [DATA_W-1:0]    in_point_z,
  input  logic signed [DATA_W-1:0]    in_quat_x,
  input  logic signed [DATA_W-1:0]    in_quat_y,
  input  logic signed [DATA_W-1:0]    in_quat_z,
  input  logic signed [DATA_W-1:0]    in_quat_w,
  input  logic signed [DATA_W-1:0]    in_trans_x,
  input  logic signed [DATA_W-1:0]    in_trans_y,
  input  logic signed [DATA_W-1:0]    in_trans_z,
  input  logic signed [DATA_W-1:0]    in_obs_u,
  input  logic signed [DATA_W-1:0]    in_obs_v,
  output logic                        out_valid,
  output logic [1:0]                  out_row_kind,
  output logic signed [DATA_W-1:0]    out_val0,
  output logic signed [DATA_W-1:0]    out_val1,
  output logic signed [DATA_W-1:0]    out_val2,
  output logic signed [DATA_W-1:0]    out_val3,
  output logic signed [DATA_W-1:0]    out_val4,
  output logic signed [DATA_W-1:0]    out_val5,
  output logic signed [DATA_W-1:0]    out_val6,
  output logic signed [DATA_W-1:0]    out_val7,
  output logic signed [DATA_W-1:0]    out_val8,
  output logic                        out_depth_ok,
  output logic                        out_last,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [DATA_W-1:0]           cfg_data
);

  localparam logic signed [DATA_W:0] ONE_Q = (DATA_W+1)'(1) <<< FRAC_BITS;

  // configuration registers
  logic [FOCAL_W-1:0]       focal_x_r, focal_y_r;
  logic signed [DATA_W-1:0] center_x_r, center_y_r;
  logic signed [DATA_W-1:0] fx_s, fy_s;

  assign fx_s = signed'({1'b0, focal_x_r});
  assign fy_s = signed'({1'b0, focal_y_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r  <= FOCAL_X_RST;
      focal_y_r  <= FOCAL_Y_RST;
      center_x_r <= CENTER_X_RST;
      center_y_r <= CENTER_Y_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FOCAL_X:  focal_x_r  <= cfg_data[FOCAL_W-1:0];
        CFG_FOCAL_Y:  focal_y_r  <= cfg_data[FOCAL_W-1:0];
        CFG_CENTER_X: center_x_r <= signed'(cfg_data);
        CFG_CENTER_Y: center_y_r <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

  // intake spacing: one transaction per result burst
  logic             accept;
  logic [GAP_W-1:0] gap_r;

  assign accept = start && !busy;
  assign busy   = !rst_n || (gap_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= '0;
    end else if (accept) begin
      gap_r <= GAP_W'(RESULTS_PER_ITEM - 1);
    end else if (gap_r != '0) begin
      gap_r <= gap_r - 1'b1;
    end
  end

  // s1: capture, quaternion clamp
  logic                     s1_v_r;
  logic signed [DATA_W-1:0] s1_pw_r [3];
  logic signed [DATA_W-1:0] s1_tr_r [3];
  logic signed [DATA_W-1:0] s1_q_r  [4];
  logic signed [DATA_W-1:0] s1_obs_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else        s1_v_r <= accept;
    if (accept) begin
      s1_pw_r[0]  <= in_point_x;
      s1_pw_r[1]  <= in_point_y;
      s1_pw_r[2]  <= in_point_z;
      s1_tr_r[0]  <= in_trans_x;
      s1_tr_r[1]  <= in_trans_y;
      s1_tr_r[2]  <= in_trans_z;
      s1_q_r[0]   <= clamp_quat(in_quat_x);
      s1_q_r[1]   <= clamp_quat(in_quat_y);
      s1_q_r[2]   <= clamp_quat(in_quat_z);
      s1_q_r[3]   <= clamp_quat(in_quat_w);
      s1_obs_r[0] <= in_obs_u;
      s1_obs_r[1] <= in_obs_v;
    end
  end

  // s2: quaternion products xx yy zz xy zw xz yw yz xw
  logic                     s2_v_r;
  logic signed [PROD_W-1:0] s2_qq_r [9];
  logic signed [DATA_W-1:0] s2_pw_r [3];
  logic signed [DATA_W-1:0] s2_tr_r [3];
  logic signed [DATA_W-1:0] s2_obs_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else        s2_v_r <= s1_v_r;
    if (s1_v_r) begin
      s2_qq_r[0] <= s1_q_r[0] * s1_q_r[0];
      s2_qq_r[1] <= s1_q_r[1] * s1_q_r[1];
      s2_qq_r[2] <= s1_q_r[2] * s1_q_r[2];
      s2_qq_r[3] <= s1_q_r[0] * s1_q_r[1];
      s2_qq_r[4] <= s1_q_r[2] * s1_q_r[3];
      s2_qq_r[5] <= s1_q_r[0] * s1_q_r[2];
      s2_qq_r[6] <= s1_q_r[1] * s1_q_r[3];
      s2_qq_r[7] <= s1_q_r[1] * s1_q_r[2];
      s2_qq_r[8] <= s1_q_r[0] * s1_q_r[3];
      s2_pw_r    <= s1_pw_r;
      s2_tr_r    <= s1_tr_r;
      s2_obs_r   <= s1_obs_r;
    end
  end

  // s3: rotation matrix in Q30
  logic                     s3_v_r;
  logic signed [DATA_W-1:0] s3_rm_r [9];
  logic signed [DATA_W-1:0] s3_pw_r [3];
  logic signed [DATA_W-1:0] s3_tr_r [3];
  logic signed [DATA_W-1:0] s3_obs_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else        s3_v_r <= s2_v_r;
    if (s2_v_r) begin
      s3_rm_r[0] <= rot_entry(ONE60 - ((wx(s2_qq_r[1]) + wx(s2_qq_r[2])) <<< 1));
      s3_rm_r[1] <= rot_entry((wx(s2_qq_r[3]) - wx(s2_qq_r[4])) <<< 1);
      s3_rm_r[2] <= rot_entry((wx(s2_qq_r[5]) + wx(s2_qq_r[6])) <<< 1);
      s3_rm_r[3] <= rot_entry((wx(s2_qq_r[3]) + wx(s2_qq_r[4])) <<< 1);
      s3_rm_r[4] <= rot_entry(ONE60 - ((wx(s2_qq_r[0]) + wx(s2_qq_r[2])) <<< 1));
      s3_rm_r[5] <= rot_entry((wx(s2_qq_r[7]) - wx(s2_qq_r[8])) <<< 1);
      s3_rm_r[6] <= rot_entry((wx(s2_qq_r[5]) - wx(s2_qq_r[6])) <<< 1);
      s3_rm_r[7] <= rot_entry((wx(s2_qq_r[7]) + wx(s2_qq_r[8])) <<< 1);
      s3_rm_r[8] <= rot_entry(ONE60 - ((wx(s2_qq_r[0]) + wx(s2_qq_r[1])) <<< 1));
      s3_pw_r    <= s2_pw_r;
      s3_tr_r    <= s2_tr_r;
      s3_obs_r   <= s2_obs_r;
    end
  end

  // s4: rotation times world point
  logic                     s4_v_r;
  logic signed [PROD_W-1:0] s4_p_r [9];
  logic signed [DATA_W-1:0] s4_rm_r [9];
  logic signed [DATA_W-1:0] s4_tr_r [3];
  logic signed [DATA_W-1:0] s4_obs_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) s4_v_r <= 1'b0;
    else        s4_v_r <= s3_v_r;
    if (s3_v_r) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          s4_p_r[i*3+k] <= s3_rm_r[i*3+k] * s3_pw_r[k];
        end
      end
      s4_rm_r  <= s3_rm_r;
      s4_tr_r  <= s3_tr_r;
      s4_obs_r <= s3_obs_r;
    end
  end

  // s5: camera point
  logic                     s5_v_r;
  logic signed [DATA_W-1:0] s5_pc_r [3];
  logic signed [DATA_W-1:0] s5_rm_r [9];
  logic signed [DATA_W-1:0] s5_obs_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) s5_v_r <= 1'b0;
    else        s5_v_r <= s4_v_r;
    if (s4_v_r) begin
      for (int i = 0; i < 3; i++) begin
        s5_pc_r[i] <= sat32(wx(PROD_W'(s4_tr_r[i]))
                            + rnd_shift(wx(s4_p_r[i*3]), QUAT_BITS)
                            + rnd_shift(wx(s4_p_r[i*3+1]), QUAT_BITS)
                            + rnd_shift(wx(s4_p_r[i*3+2]), QUAT_BITS));
      end
      s5_rm_r  <= s4_rm_r;
      s5_obs_r <= s4_obs_r;
    end
  end

  // s6: divider numerators x, y, fx, fy scaled by one; fx*x, fy*y
  logic                     s6_v_r;
  logic signed [NUM_W-1:0]  s6_num_r [NUM_LANES];
  dside_t                   s6_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s6_v_r <= 1'b0;
    else        s6_v_r <= s5_v_r;
    if (s5_v_r) begin
      s6_num_r[0]     <= NUM_W'(s5_pc_r[0]) <<< FRAC_BITS;
      s6_num_r[1]     <= NUM_W'(s5_pc_r[1]) <<< FRAC_BITS;
      s6_num_r[2]     <= NUM_W'(fx_s) <<< FRAC_BITS;
      s6_num_r[3]     <= NUM_W'(fy_s) <<< FRAC_BITS;
      s6_num_r[4]     <= fx_s * s5_pc_r[0];
      s6_num_r[5]     <= fy_s * s5_pc_r[1];
      s6_side_r.ok    <= s5_pc_r[2] > 0;
      s6_side_r.den   <= s5_pc_r[2];
      s6_side_r.obs_u <= s5_obs_r[0];
      s6_side_r.obs_v <= s5_obs_r[1];
      for (int k = 0; k < 9; k++) begin
        s6_side_r.rm[k] <= s5_rm_r[k];
      end
    end
  end

  // divider: stage 0 prepares, each later stage resolves one quotient bit
  logic   dv_v_r    [QUO_W+1];
  dside_t dv_side_r [QUO_W+1];
  dlane_t dv_lane_r [QUO_W+1][NUM_LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) dv_v_r[0] <= 1'b0;
    else        dv_v_r[0] <= s6_v_r;
    if (s6_v_r) begin
      dv_side_r[0] <= s6_side_r;
      for (int l = 0; l < NUM_LANES; l++) begin
        dv_lane_r[0][l] <= div_init(s6_num_r[l], s6_side_r.den);
      end
    end
  end

  for (genvar s = 0; s < QUO_W; s++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) dv_v_r[s+1] <= 1'b0;
      else        dv_v_r[s+1] <= dv_v_r[s];
      if (dv_v_r[s]) begin
        dv_side_r[s+1] <= dv_side_r[s];
        for (int l = 0; l < NUM_LANES; l++) begin
          dv_lane_r[s+1][l] <= div_step(dv_lane_r[s][l], dv_side_r[s].den);
        end
      end
    end
  end

  // p1: projected ratios and residual
  logic                     p1_v_r, p1_ok_r;
  logic signed [DATA_W-1:0] p1_a_r, p1_b_r, p1_fxz_r, p1_fyz_r;
  logic signed [DATA_W-1:0] p1_res_r [2];
  logic signed [DATA_W-1:0] p1_rm_r  [9];

  always_ff @(posedge clk) begin
    if (!rst_n) p1_v_r <= 1'b0;
    else        p1_v_r <= dv_v_r[QUO_W];
    if (dv_v_r[QUO_W]) begin
      p1_a_r      <= sat32(quo_value(dv_lane_r[QUO_W][0]));
      p1_b_r      <= sat32(quo_value(dv_lane_r[QUO_W][1]));
      p1_fxz_r    <= sat32(quo_value(dv_lane_r[QUO_W][2]));
      p1_fyz_r    <= sat32(quo_value(dv_lane_r[QUO_W][3]));
      p1_res_r[0] <= sat32(wx(PROD_W'(signed'(dv_side_r[QUO_W].obs_u)))
                           - (quo_value(dv_lane_r[QUO_W][4]) + wx(PROD_W'(center_x_r))));
      p1_res_r[1] <= sat32(wx(PROD_W'(signed'(dv_side_r[QUO_W].obs_v)))
                           - (quo_value(dv_lane_r[QUO_W][5]) + wx(PROD_W'(center_y_r))));
      p1_ok_r     <= dv_side_r[QUO_W].ok;
      for (int k = 0; k < 9; k++) begin
        p1_rm_r[k] <= signed'(dv_side_r[QUO_W].rm[k]);
      end
    end
  end

  // p2: products of the ratios
  logic                     p2_v_r, p2_ok_r;
  logic signed [PROD_W-1:0] p2_ab_r, p2_aa_r, p2_bb_r, p2_fxza_r, p2_fyzb_r;
  logic signed [PROD_W-1:0] p2_fxb_r, p2_fya_r;
  logic signed [DATA_W-1:0] p2_fxz_r, p2_fyz_r;
  logic signed [DATA_W-1:0] p2_res_r [2];
  logic signed [DATA_W-1:0] p2_rm_r  [9];

  always_ff @(posedge clk) begin
    if (!rst_n) p2_v_r <= 1'b0;
    else        p2_v_r <= p1_v_r;
    if (p1_v_r) begin
      p2_ab_r   <= p1_a_r * p1_b_r;
      p2_aa_r   <= p1_a_r * p1_a_r;
      p2_bb_r   <= p1_b_r * p1_b_r;
      p2_fxza_r <= p1_fxz_r * p1_a_r;
      p2_fyzb_r <= p1_fyz_r * p1_b_r;
      p2_fxb_r  <= fx_s * p1_b_r;
      p2_fya_r  <= fy_s * p1_a_r;
      p2_fxz_r  <= p1_fxz_r;
      p2_fyz_r  <= p1_fyz_r;
      p2_res_r  <= p1_res_r;
      p2_rm_r   <= p1_rm_r;
      p2_ok_r   <= p1_ok_r;
    end
  end

  // p3: rounded ratio products
  logic                     p3_v_r, p3_ok_r;
  logic signed [DATA_W-1:0] p3_ab_r, p3_aa_r, p3_bb_r, p3_jt02_r, p3_jt12_r;
  logic signed [DATA_W-1:0] p3_v18_r, p3_v28_r, p3_fxz_r, p3_fyz_r;
  logic signed [DATA_W-1:0] p3_res_r [2];
  logic signed [DATA_W-1:0] p3_rm_r  [9];

  always_ff @(posedge clk) begin
    if (!rst_n) p3_v_r <= 1'b0;
    else        p3_v_r <= p2_v_r;
    if (p2_v_r) begin
      p3_ab_r   <= sat32(rnd_shift(wx(p2_ab_r), FRAC_BITS));
      p3_aa_r   <= sat32(rnd_shift(wx(p2_aa_r), FRAC_BITS));
      p3_bb_r   <= sat32(rnd_shift(wx(p2_bb_r), FRAC_BITS));
      p3_jt02_r <= sat32(rnd_shift(wx(p2_fxza_r), FRAC_BITS));
      p3_jt12_r <= sat32(rnd_shift(wx(p2_fyzb_r), FRAC_BITS));
      p3_v18_r  <= sat32(rnd_shift(wx(p2_fxb_r), FRAC_BITS));
      p3_v28_r  <= sat32(-rnd_shift(wx(p2_fya_r), FRAC_BITS));
      p3_fxz_r  <= p2_fxz_r;
      p3_fyz_r  <= p2_fyz_r;
      p3_res_r  <= p2_res_r;
      p3_rm_r   <= p2_rm_r;
      p3_ok_r   <= p2_ok_r;
    end
  end

  // p4: jacobian times rotation, rotation derivative products
  logic                     p4_v_r, p4_ok_r;
  logic signed [PROD_W-1:0] p4_m0_r [3], p4_m0z_r [3], p4_m1_r [3], p4_m1z_r [3];
  logic signed [PROD_W-1:0] p4_pa_r, p4_pb_r, p4_pc_r, p4_pd_r;
  logic signed [DATA_W-1:0] p4_jt02_r, p4_jt12_r, p4_v18_r, p4_v28_r;
  logic signed [DATA_W-1:0] p4_fxz_r, p4_fyz_r;
  logic signed [DATA_W-1:0] p4_res_r [2];
  logic signed [DATA_W:0]   one_aa, one_bb;

  assign one_aa = ONE_Q + (DATA_W+1)'(p3_aa_r);
  assign one_bb = ONE_Q + (DATA_W+1)'(p3_bb_r);

  always_ff @(posedge clk) begin
    if (!rst_n) p4_v_r <= 1'b0;
    else        p4_v_r <= p3_v_r;
    if (p3_v_r) begin
      for (int j = 0; j < 3; j++) begin
        p4_m0_r[j]  <= (-p3_fxz_r) * p3_rm_r[j];
        p4_m0z_r[j] <= p3_jt02_r * p3_rm_r[6+j];
        p4_m1_r[j]  <= (-p3_fyz_r) * p3_rm_r[3+j];
        p4_m1z_r[j] <= p3_jt12_r * p3_rm_r[6+j];
      end
      p4_pa_r   <= fx_s * p3_ab_r;
      p4_pb_r   <= fx_s * one_aa;
      p4_pc_r   <= fy_s * one_bb;
      p4_pd_r   <= fy_s * p3_ab_r;
      p4_jt02_r <= p3_jt02_r;
      p4_jt12_r <= p3_jt12_r;
      p4_v18_r  <= p3_v18_r;
      p4_v28_r  <= p3_v28_r;
      p4_fxz_r  <= p3_fxz_r;
      p4_fyz_r  <= p3_fyz_r;
      p4_res_r  <= p3_res_r;
      p4_ok_r   <= p3_ok_r;
    end
  end

  // p5: final rows
  logic                     p5_v_r, p5_ok_r;
  logic signed [DATA_W-1:0] p5_row1_r [9];
  logic signed [DATA_W-1:0] p5_row2_r [9];
  logic signed [DATA_W-1:0] p5_res_r  [2];

  always_ff @(posedge clk) begin
    if (!rst_n) p5_v_r <= 1'b0;
    else        p5_v_r <= p4_v_r;
    if (p4_v_r) begin
      for (int j = 0; j < 3; j++) begin
        p5_row1_r[j] <= sat32(rnd_shift(wx(p4_m0_r[j]), QUAT_BITS)
                              + rnd_shift(wx(p4_m0z_r[j]), QUAT_BITS));
        p5_row2_r[j] <= sat32(rnd_shift(wx(p4_m1_r[j]), QUAT_BITS)
                              + rnd_shift(wx(p4_m1z_r[j]), QUAT_BITS));
      end
      p5_row1_r[3] <= -p4_fxz_r;
      p5_row1_r[4] <= '0;
      p5_row1_r[5] <= p4_jt02_r;
      p5_row1_r[6] <= sat32(rnd_shift(wx(p4_pa_r), FRAC_BITS));
      p5_row1_r[7] <= sat32(-rnd_shift(wx(p4_pb_r), FRAC_BITS));
      p5_row1_r[8] <= p4_v18_r;
      p5_row2_r[3] <= '0;
      p5_row2_r[4] <= -p4_fyz_r;
      p5_row2_r[5] <= p4_jt12_r;
      p5_row2_r[6] <= sat32(rnd_shift(wx(p4_pc_r), FRAC_BITS));
      p5_row2_r[7] <= sat32(-rnd_shift(wx(p4_pd_r), FRAC_BITS));
      p5_row2_r[8] <= p4_v28_r;
      p5_res_r     <= p4_res_r;
      p5_ok_r      <= p4_ok_r;
    end
  end

  // output sequencer: residual, row 0, row 1 on consecutive cycles
  logic                     out_valid_r, out_valid_nxt;
  logic [1:0]               out_kind_r, out_kind_nxt;
  logic                     out_last_r, out_last_nxt;
  logic                     out_ok_r, out_ok_nxt;
  logic signed [DATA_W-1:0] out_val_r [9];
  logic signed [DATA_W-1:0] out_val_nxt [9];
  logic [1:0]               phase_r, phase_nxt;

  always_comb begin
    out_valid_nxt = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_last_nxt  = 1'b0;
    out_ok_nxt    = p5_ok_r;
    phase_nxt     = '0;
    for (int k = 0; k < 9; k++) out_val_nxt[k] = '0;
    if (p5_v_r) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = ROW_RESID;
      phase_nxt     = 2'(ROW_JAC0);
      out_val_nxt[0] = p5_res_r[0];
      out_val_nxt[1] = p5_res_r[1];
    end else if (phase_r == 2'(ROW_JAC0)) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = ROW_JAC0;
      phase_nxt     = 2'(ROW_JAC1);
      out_val_nxt   = p5_row1_r;
    end else if (phase_r == 2'(ROW_JAC1)) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = ROW_JAC1;
      out_last_nxt  = 1'b1;
      out_val_nxt   = p5_row2_r;
    end
    // depth not positive: every value reads zero
    if (!p5_ok_r) begin
      for (int k = 0; k < 9; k++) out_val_nxt[k] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      phase_r     <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
      phase_r     <= phase_nxt;
    end
    out_kind_r <= out_kind_nxt;
    out_ok_r   <= out_ok_nxt;
    out_val_r  <= out_val_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_row_kind = out_kind_r;
  assign out_last     = out_last_r;
  assign out_depth_ok = out_ok_r;
  assign out_val0     = out_val_r[0];
  assign out_val1     = out_val_r[1];
  assign out_val2     = out_val_r[2];
  assign out_val3     = out_val_r[3];
  assign out_val4     = out_val_r[4];
  assign out_val5     = out_val_r[5];
  assign out_val6     = out_val_r[6];
  assign out_val7     = out_val_r[7];
  assign out_val8     = out_val_r[8];

endmodule

@@ hdl/rrj_checker.sv @@
// ---------------------------------------------------------------------------
// rrj_checker
// Port-level checks on intake spacing and result ordering.
// ---------------------------------------------------------------------------
module rrj_checker
  import rrj_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     start,
  input logic                     busy,
  input logic                     out_valid,
  input logic [1:0]               out_row_kind,
  input logic                     out_last,
  input logic                     out_depth_ok,
  input logic signed [DATA_W-1:0] out_val0,
  input logic signed [DATA_W-1:0] out_val1,
  input logic signed [DATA_W-1:0] out_val2,
  input logic signed [DATA_W-1:0] out_val3,
  input logic signed [DATA_W-1:0] out_val4,
  input logic signed [DATA_W-1:0] out_val5,
  input logic signed [DATA_W-1:0] out_val6,
  input logic signed [DATA_W-1:0] out_val7,
  input logic signed [DATA_W-1:0] out_val8
);

  // a taken transaction closes the intake for the next cycle
  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("intake open right after a transaction");

  // residual is followed by the first jacobian row
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_row_kind == 2'(ROW_RESID) |=>
      out_valid && out_row_kind == 2'(ROW_JAC0))
    else $error("result burst out of order");

  // last marks the second jacobian row only
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_row_kind == 2'(ROW_JAC1))
    else $error("last on wrong result");

  // bad depth gives all-zero values
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_depth_ok |->
      out_val0 == 0 && out_val1 == 0 && out_val2 == 0 && out_val3 == 0 &&
      out_val4 == 0 && out_val5 == 0 && out_val6 == 0 && out_val7 == 0 &&
      out_val8 == 0)
    else $error("nonzero value with bad depth");

  // reset empties the result port
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind reprojection_residual_jacobian_top rrj_checker u_rrj_checker (.*);
